>>> sv/vrrb_pkg.sv
// shared types and constants of the variable record ring buffer
`default_nettype none

package vrrb_pkg;

  // ring geometry
  localparam int BUF_BYTES   = 4096;
  localparam int CAP_MIN     = 64;
  localparam int HDR_BYTES   = 16;
  localparam int HDR_LOG2    = 4;
  localparam int ALIGN_BYTES = 8;
  localparam int ALIGN_LOG2  = 3;

  // field and state widths
  localparam int OFF_W   = 12;
  localparam int SIZE_W  = 13;
  localparam int NEED_W  = 14;
  localparam int CNT_W   = 10;
  localparam int SLOTS   = 512;
  localparam int SLOT_W  = 9;
  localparam int ENTRY_W = SIZE_W + 1;

  // result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NEVER  = 2'd1;
  localparam logic [1:0] ST_NOROOM = 2'd2;
  localparam logic [1:0] ST_EMPTY  = 2'd3;

  // action codes
  localparam logic ACT_PUSH = 1'b0;

  typedef struct packed {
    logic              action;
    logic [SIZE_W-1:0] record_bytes;
  } vrrb_in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [OFF_W-1:0]  offset;
    logic [SIZE_W-1:0] popped_bytes;
    logic [SIZE_W-1:0] free_bytes;
  } vrrb_out_t;

endpackage

`default_nettype wire

>>> sv/variable_record_ring_buffer.sv
// Variable record ring buffer: one push or pop at a time on a shared add/sub unit.
// The sequencer takes an item only while idle and raises in_stall_o otherwise; the next item
// is taken while a result waits. A pop first frees dropped records at the head.
// Reset empties the ring and sets capacity to 4096; the record store is not cleared.
`default_nettype none

module variable_record_ring_buffer import vrrb_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire vrrb_in_t          in_item_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output vrrb_out_t              out_item_o,
  input  wire logic              cfg_we_i,
  input  wire logic [SIZE_W-1:0] cfg_data_i
);

  // sequencer state codes
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_NEED    = 4'd1;
  localparam logic [3:0] S_CAP     = 4'd2;
  localparam logic [3:0] S_DIFF    = 4'd3;
  localparam logic [3:0] S_FREE    = 4'd4;
  localparam logic [3:0] S_ROOM    = 4'd5;
  localparam logic [3:0] S_GAP     = 4'd6;
  localparam logic [3:0] S_GAPCHK  = 4'd7;
  localparam logic [3:0] S_HEADCHK = 4'd8;
  localparam logic [3:0] S_PLACE   = 4'd9;
  localparam logic [3:0] S_TWRAP   = 4'd10;
  localparam logic [3:0] S_PRD     = 4'd11;
  localparam logic [3:0] S_PCHK    = 4'd12;
  localparam logic [3:0] S_PADV    = 4'd13;

  localparam logic [NEED_W-1:0] NEED_MASK = ~NEED_W'(ALIGN_BYTES - 1);

  logic [3:0]        state_q, state_d;
  logic [OFF_W-1:0]  head_q, head_d;
  logic [OFF_W-1:0]  tail_q, tail_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [SIZE_W-1:0] cap_q, cap_d;
  logic              out_valid_q, out_valid_d;
  vrrb_out_t         out_q, out_d;

  logic [SIZE_W-1:0] bytes_q, bytes_d;
  logic [NEED_W-1:0] need_q, need_d;
  logic [SIZE_W-1:0] diff_q, diff_d;
  logic              wrap_q, wrap_d;
  logic [SIZE_W-1:0] free_q, free_d;
  logic [SIZE_W-1:0] gap_q, gap_d;
  logic [SIZE_W-1:0] sum_q, sum_d;
  logic              fin_q, fin_d;
  logic [1:0]        status_q, status_d;
  logic [OFF_W-1:0]  offset_q, offset_d;
  logic [SIZE_W-1:0] popped_q, popped_d;

  // record store: size plus drop flag per aligned slot
  logic [ENTRY_W-1:0] store_q [SLOTS];
  logic [ENTRY_W-1:0] rdata_q;
  logic               mem_we;
  logic [SLOT_W-1:0]  mem_wa;
  logic [ENTRY_W-1:0] mem_wd;

  // shared add/sub unit
  logic [NEED_W-1:0] unit_a, unit_b;
  logic              unit_sub;
  logic [NEED_W:0]   unit_res;

  logic              out_load;
  logic [SIZE_W-1:0] free_w;
  logic [SIZE_W-1:0] cfg_clamp_w;

  assign unit_res = unit_sub ? ({1'b0, unit_a} - {1'b0, unit_b})
                             : ({1'b0, unit_a} + {1'b0, unit_b});

  // capacity clamp and alignment on a register write
  always_comb begin
    if (cfg_data_i < SIZE_W'(CAP_MIN)) begin
      cfg_clamp_w = SIZE_W'(CAP_MIN);
    end else if (cfg_data_i > SIZE_W'(BUF_BYTES)) begin
      cfg_clamp_w = SIZE_W'(BUF_BYTES);
    end else begin
      cfg_clamp_w = cfg_data_i;
    end
    cfg_clamp_w = cfg_clamp_w & NEED_MASK[SIZE_W-1:0];
  end

  // free space select; the wrapped case uses the unit in the free state
  always_comb begin
    if (count_q == '0) begin
      free_w = cap_q;
    end else if (wrap_q) begin
      free_w = unit_res[SIZE_W-1:0];
    end else begin
      free_w = diff_q;
    end
  end

  // sequencer
  always_comb begin
    state_d  = state_q;
    head_d   = head_q;
    tail_d   = tail_q;
    count_d  = count_q;
    cap_d    = cap_q;
    bytes_d  = bytes_q;
    need_d   = need_q;
    diff_d   = diff_q;
    wrap_d   = wrap_q;
    free_d   = free_q;
    gap_d    = gap_q;
    sum_d    = sum_q;
    fin_d    = fin_q;
    status_d = status_q;
    offset_d = offset_q;
    popped_d = popped_q;
    mem_we   = 1'b0;
    mem_wa   = head_q[OFF_W-1:ALIGN_LOG2];
    mem_wd   = rdata_q;
    unit_a   = '0;
    unit_b   = '0;
    unit_sub = 1'b0;
    out_load = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          bytes_d  = in_item_i.record_bytes;
          status_d = ST_OK;
          offset_d = '0;
          popped_d = '0;
          if (in_item_i.action == ACT_PUSH) begin
            state_d = S_NEED;
          end else if (count_q == '0) begin
            status_d = ST_EMPTY;
            fin_d    = 1'b1;
            state_d  = S_DIFF;
          end else begin
            state_d = S_PRD;
          end
        end
      end
      // round the size up to the alignment
      S_NEED: begin
        unit_a  = {1'b0, bytes_q};
        unit_b  = NEED_W'(ALIGN_BYTES - 1);
        need_d  = unit_res[NEED_W-1:0] & NEED_MASK;
        fin_d   = 1'b0;
        state_d = S_CAP;
      end
      // record that can never fit
      S_CAP: begin
        unit_a   = {1'b0, cap_q};
        unit_b   = need_q;
        unit_sub = 1'b1;
        if (unit_res[NEED_W] || bytes_q < SIZE_W'(HDR_BYTES)) begin
          status_d = ST_NEVER;
          fin_d    = 1'b1;
        end
        state_d = S_DIFF;
      end
      // head minus tail, borrow tells a wrapped ring
      S_DIFF: begin
        unit_a   = {2'b00, head_q};
        unit_b   = {2'b00, tail_q};
        unit_sub = 1'b1;
        diff_d   = unit_res[SIZE_W-1:0];
        wrap_d   = unit_res[NEED_W];
        state_d  = S_FREE;
      end
      S_FREE: begin
        unit_a = {1'b0, cap_q};
        unit_b = {1'b0, diff_q};
        if (fin_q) begin
          if (!out_valid_q || !out_stall_i) begin
            out_load = 1'b1;
            state_d  = S_IDLE;
          end
        end else begin
          free_d  = free_w;
          state_d = S_ROOM;
        end
      end
      // room check against current free space
      S_ROOM: begin
        unit_a   = {1'b0, free_q};
        unit_b   = need_q;
        unit_sub = 1'b1;
        if (unit_res[NEED_W]) begin
          status_d = ST_NOROOM;
          fin_d    = 1'b1;
          state_d  = S_DIFF;
        end else if (count_q != '0 && wrap_q) begin
          state_d = S_GAP;
        end else begin
          state_d = S_PLACE;
        end
      end
      S_GAP: begin
        unit_a   = {1'b0, cap_q};
        unit_b   = {2'b00, tail_q};
        unit_sub = 1'b1;
        gap_d    = unit_res[SIZE_W-1:0];
        state_d  = S_GAPCHK;
      end
      // end gap below size plus header
      S_GAPCHK: begin
        unit_a   = {1'b0, gap_q};
        unit_b   = need_q;
        unit_sub = 1'b1;
        if (unit_res[NEED_W] || unit_res[NEED_W-1:HDR_LOG2] == '0) begin
          state_d = S_HEADCHK;
        end else begin
          state_d = S_PLACE;
        end
      end
      // head gap must take the record, then a dummy fills the end gap
      S_HEADCHK: begin
        unit_a   = {2'b00, head_q};
        unit_b   = need_q;
        unit_sub = 1'b1;
        if (unit_res[NEED_W]) begin
          status_d = ST_NOROOM;
          fin_d    = 1'b1;
          state_d  = S_DIFF;
        end else begin
          mem_we  = 1'b1;
          mem_wa  = tail_q[OFF_W-1:ALIGN_LOG2];
          mem_wd  = {1'b1, gap_q};
          count_d = count_q + CNT_W'(1);
          tail_d  = '0;
          state_d = S_PLACE;
        end
      end
      S_PLACE: begin
        unit_a   = {2'b00, tail_q};
        unit_b   = need_q;
        mem_we   = 1'b1;
        mem_wa   = tail_q[OFF_W-1:ALIGN_LOG2];
        mem_wd   = {1'b0, need_q[SIZE_W-1:0]};
        offset_d = tail_q;
        count_d  = count_q + CNT_W'(1);
        sum_d    = unit_res[SIZE_W-1:0];
        state_d  = S_TWRAP;
      end
      S_TWRAP: begin
        unit_a   = {1'b0, sum_q};
        unit_b   = {1'b0, cap_q};
        unit_sub = 1'b1;
        tail_d   = unit_res[NEED_W] ? sum_q[OFF_W-1:0] : '0;
        fin_d    = 1'b1;
        state_d  = S_DIFF;
      end
      // store read of the head slot
      S_PRD: begin
        state_d = S_PCHK;
      end
      S_PCHK: begin
        unit_a = {2'b00, head_q};
        unit_b = {1'b0, rdata_q[SIZE_W-1:0]};
        if (rdata_q[SIZE_W]) begin
          sum_d   = unit_res[SIZE_W-1:0];
          count_d = count_q - CNT_W'(1);
          state_d = S_PADV;
        end else begin
          mem_we   = 1'b1;
          mem_wd   = {1'b1, rdata_q[SIZE_W-1:0]};
          offset_d = head_q;
          popped_d = rdata_q[SIZE_W-1:0];
          fin_d    = 1'b1;
          state_d  = S_DIFF;
        end
      end
      // advance head past a dropped record
      S_PADV: begin
        unit_a   = {1'b0, sum_q};
        unit_b   = {1'b0, cap_q};
        unit_sub = 1'b1;
        head_d   = unit_res[NEED_W] ? sum_q[OFF_W-1:0] : '0;
        if (count_q == '0) begin
          head_d   = '0;
          tail_d   = '0;
          status_d = ST_EMPTY;
          fin_d    = 1'b1;
          state_d  = S_DIFF;
        end else begin
          state_d = S_PRD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // capacity write empties the ring
    if (cfg_we_i) begin
      cap_d   = cfg_clamp_w;
      head_d  = '0;
      tail_d  = '0;
      count_d = '0;
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_load | (out_valid_q & out_stall_i);
    out_d       = out_q;
    if (out_load) begin
      out_d.status       = status_q;
      out_d.offset       = offset_q;
      out_d.popped_bytes = popped_q;
      out_d.free_bytes   = free_w;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      cap_q       <= SIZE_W'(BUF_BYTES);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      cap_q       <= cap_d;
      out_valid_q <= out_valid_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    bytes_q  <= bytes_d;
    need_q   <= need_d;
    diff_q   <= diff_d;
    wrap_q   <= wrap_d;
    free_q   <= free_d;
    gap_q    <= gap_d;
    sum_q    <= sum_d;
    fin_q    <= fin_d;
    status_q <= status_d;
    offset_q <= offset_d;
    popped_q <= popped_d;
    out_q    <= out_d;
  end

  // record store, read at the head slot every cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_q[mem_wa] <= mem_wd;
    end
    rdata_q <= store_q[head_q[OFF_W-1:ALIGN_LOG2]];
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef SYNTHESIS
  // an empty ring sits at offset zero
  a_empty_at_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && count_q == '0) |-> (head_q == '0 && tail_q == '0))
    else $error("empty ring with nonzero head or tail");

  // head and tail stay inside the ring
  a_inside_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> ({1'b0, head_q} < cap_q && {1'b0, tail_q} < cap_q))
    else $error("head or tail beyond capacity");

  // head record is only examined while records remain
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PCHK) |-> (count_q != '0))
    else $error("head record checked on an empty ring");
`endif

endmodule

`default_nettype wire

>>> bench/tb_top.sv
// testbench for the variable record ring buffer, checked against a predictor of the ring
`timescale 1ns / 100ps

module tb_top;
  import vrrb_pkg::*;

  localparam int HALF_PERIOD   = 5;
  localparam int RESET_CYCLES  = 12;
  localparam int SETTLE_CYCLES = 16;
  localparam int TAIL_CYCLES   = 20;
  localparam int HOLD_CYCLES   = 300;
  localparam int WD_LIMIT      = 3000;
  localparam int PRINT_LIMIT   = 40;
  localparam int PHASES        = 9;
  localparam int PHASE_ITEMS   = 160;
  localparam int BURST_ITEMS   = 20;
  localparam logic ACT_POP     = ~ACT_PUSH;

  // one line of the directed table
  typedef enum logic [1:0] {ROW_PUSH, ROW_POP, ROW_CFG} row_kind_e;
  typedef struct packed {
    row_kind_e         kind;
    logic [SIZE_W-1:0] value;
    logic              typed;
    vrrb_out_t         want;
  } row_t;

  // one ring slot: record size plus drop flag
  typedef struct packed {
    logic              dropped;
    logic [SIZE_W-1:0] bytes;
  } slot_t;

  localparam vrrb_out_t NO_WANT = '0;
  localparam int DIR_ROWS_N = 29;
  localparam row_t DIR_ROWS [DIR_ROWS_N] = '{
    {ROW_POP,  13'd0,    1'b1, ST_EMPTY,  12'd0, 13'd0, 13'd4096},
    {ROW_PUSH, 13'd0,    1'b1, ST_NEVER,  12'd0, 13'd0, 13'd4096},
    {ROW_PUSH, 13'd15,   1'b1, ST_NEVER,  12'd0, 13'd0, 13'd4096},
    {ROW_PUSH, 13'd8191, 1'b1, ST_NEVER,  12'd0, 13'd0, 13'd4096},
    {ROW_PUSH, 13'd4097, 1'b1, ST_NEVER,  12'd0, 13'd0, 13'd4096},
    {ROW_PUSH, 13'd16,   1'b1, ST_OK,     12'd0, 13'd0, 13'd4080},
    {ROW_PUSH, 13'd17,   1'b0, NO_WANT},
    {ROW_POP,  13'd0,    1'b0, NO_WANT},
    {ROW_POP,  13'd0,    1'b0, NO_WANT},
    {ROW_POP,  13'd0,    1'b0, NO_WANT},
    // whole ring in one record, then a refusal on a full ring
    {ROW_PUSH, 13'd4096, 1'b1, ST_OK,     12'd0, 13'd0, 13'd0},
    {ROW_PUSH, 13'd16,   1'b1, ST_NOROOM, 12'd0, 13'd0, 13'd0},
    {ROW_POP,  13'd0,    1'b0, NO_WANT},
    {ROW_POP,  13'd0,    1'b1, ST_EMPTY,  12'd0, 13'd0, 13'd4096},
    // smallest ring, clamped up from zero
    {ROW_CFG,  13'd0,    1'b0, NO_WANT},
    {ROW_PUSH, 13'd65,   1'b1, ST_NEVER,  12'd0, 13'd0, 13'd64},
    {ROW_PUSH, 13'd24,   1'b0, NO_WANT},
    {ROW_PUSH, 13'd24,   1'b0, NO_WANT},
    {ROW_POP,  13'd0,    1'b0, NO_WANT},
    // end gap too small and head too close: refused
    {ROW_PUSH, 13'd16,   1'b0, NO_WANT},
    {ROW_POP,  13'd0,    1'b0, NO_WANT},
    // end gap filled and tail wraps, then a pop skips two dropped records
    {ROW_PUSH, 13'd16,   1'b0, NO_WANT},
    {ROW_POP,  13'd0,    1'b0, NO_WANT},
    {ROW_POP,  13'd0,    1'b0, NO_WANT},
    // a capacity write empties a ring that still holds a record
    {ROW_PUSH, 13'd32,   1'b0, NO_WANT},
    {ROW_CFG,  13'd8191, 1'b0, NO_WANT},
    {ROW_POP,  13'd0,    1'b1, ST_EMPTY,  12'd0, 13'd0, 13'd4096},
    {ROW_CFG,  13'd100,  1'b0, NO_WANT},
    {ROW_PUSH, 13'd8,    1'b1, ST_NEVER,  12'd0, 13'd0, 13'd96}
  };

  localparam logic [SIZE_W-1:0] PHASE_CAP [PHASES] = '{
    13'd4096, 13'd64, 13'd8191, 13'd200, 13'd1000, 13'd0, 13'd4095, 13'd512, 13'd4096
  };

  // block signals
  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  vrrb_in_t          in_item = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  vrrb_out_t         out_item;
  logic              cfg_we = 1'b0;
  logic [SIZE_W-1:0] cfg_data = '0;

  // typed expectation that travels with a directed item
  logic              want_en = 1'b0;
  vrrb_out_t         want_val = '0;

  // idling control
  logic              calm = 1'b0;
  int unsigned       hold_req = 0;

  // predicted ring state
  logic [SIZE_W-1:0] ring_cap;
  logic [OFF_W-1:0]  ring_head;
  logic [OFF_W-1:0]  ring_tail;
  logic [CNT_W-1:0]  ring_count;
  slot_t             ring_slots [SLOTS];

  // results still owed by the block, oldest first
  vrrb_out_t         owed_results [$];

  int unsigned fail_count = 0;
  int unsigned items_in = 0;
  int unsigned results_out = 0;
  int unsigned status_hits [4] = '{0, 0, 0, 0};
  int unsigned wrap_fills = 0;
  int unsigned max_skipped = 0;
  int unsigned cap_writes = 0;
  int unsigned idle_cycles = 0;

  variable_record_ring_buffer i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // free bytes of the predicted ring
  function automatic logic [SIZE_W-1:0] ring_free();
    if (ring_count == 0) return ring_cap;
    if (ring_head < ring_tail) return ring_cap - ring_tail + ring_head;
    return ring_head - ring_tail;
  endfunction

  // advance the predicted ring by one push or pop and return its result
  function automatic vrrb_out_t ring_step(vrrb_in_t it);
    vrrb_out_t   res;
    int unsigned need;
    int unsigned pos;
    int unsigned skipped;
    res = '0;
    skipped = 0;
    need = (int'(it.record_bytes) + ALIGN_BYTES - 1) / ALIGN_BYTES * ALIGN_BYTES;
    if (it.action == ACT_PUSH) begin
      if (it.record_bytes < HDR_BYTES || need > ring_cap) begin
        res.status = ST_NEVER;
      end else if (need > ring_free()) begin
        res.status = ST_NOROOM;
      end else if (ring_count != 0 && ring_head < ring_tail
                   && ring_cap - ring_tail < need + HDR_BYTES) begin
        // end gap too small: the head gap must take the record
        if (ring_head < need) begin
          res.status = ST_NOROOM;
        end else begin
          ring_slots[ring_tail[OFF_W-1:ALIGN_LOG2]] = {1'b1, SIZE_W'(ring_cap - ring_tail)};
          ring_count++;
          ring_tail = '0;
          wrap_fills++;
        end
      end
      // place the record at the tail
      if (res.status == ST_OK) begin
        res.offset = ring_tail;
        ring_slots[ring_tail[OFF_W-1:ALIGN_LOG2]] = {1'b0, SIZE_W'(need)};
        ring_count++;
        pos = ring_tail + need;
        ring_tail = (pos >= ring_cap) ? '0 : OFF_W'(pos);
      end
    end else if (ring_count == 0) begin
      res.status = ST_EMPTY;
    end else begin
      // free dropped records at the head
      while (ring_count != 0 && ring_slots[ring_head[OFF_W-1:ALIGN_LOG2]].dropped) begin
        pos = ring_head + ring_slots[ring_head[OFF_W-1:ALIGN_LOG2]].bytes;
        ring_head = (pos >= ring_cap) ? '0 : OFF_W'(pos);
        ring_count--;
        skipped++;
      end
      if (skipped > max_skipped) max_skipped = skipped;
      if (ring_count == 0) begin
        ring_head = '0;
        ring_tail = '0;
        res.status = ST_EMPTY;
      end else begin
        ring_slots[ring_head[OFF_W-1:ALIGN_LOG2]].dropped = 1'b1;
        res.offset = ring_head;
        res.popped_bytes = ring_slots[ring_head[OFF_W-1:ALIGN_LOG2]].bytes;
      end
    end
    res.free_bytes = ring_free();
    return res;
  endfunction

  // random push or pop, mostly well-formed sizes for the current capacity
  function automatic vrrb_in_t random_item(bit filling);
    vrrb_in_t    it;
    int unsigned pick;
    int unsigned top;
    pick = $urandom_range(0, 99);
    top = (ring_cap / 4 > HDR_BYTES) ? ring_cap / 4 : HDR_BYTES;
    it.action = ($urandom_range(0, 99) < (filling ? 30 : 70)) ? ACT_POP : ACT_PUSH;
    if (pick < 70) it.record_bytes = SIZE_W'($urandom_range(HDR_BYTES, top));
    else if (pick < 80) it.record_bytes = SIZE_W'($urandom_range(HDR_BYTES, ring_cap));
    else if (pick < 90) it.record_bytes = SIZE_W'($urandom_range(0, HDR_BYTES - 1));
    else it.record_bytes = SIZE_W'($urandom_range(0, (1 << SIZE_W) - 1));
    return it;
  endfunction

  task automatic log_mismatch(string what, int unsigned got, int unsigned want);
    fail_count++;
    if (fail_count <= PRINT_LIMIT) begin
      $display("mismatch on result %0d: %s got %0d expected %0d", results_out, what, got, want);
    end
  endtask

  // offer one item and hold it until the transfer
  task automatic send_item(vrrb_in_t it, logic typed, vrrb_out_t want);
    if (!calm && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    want_en  <= typed;
    want_val <= want;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    // let the check process book the last transfer before looking at what is owed
    @(posedge clk);
    while (owed_results.size() != 0) @(posedge clk);
  endtask

  // capacity write on an idle block; clamped and aligned like the block does
  task automatic write_capacity(logic [SIZE_W-1:0] value);
    int unsigned v;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    v = 32'(value);
    if (v < CAP_MIN) v = CAP_MIN;
    if (v > BUF_BYTES) v = BUF_BYTES;
    ring_cap   = SIZE_W'(v - v % ALIGN_BYTES);
    ring_head  = '0;
    ring_tail  = '0;
    ring_count = '0;
    cap_writes++;
  endtask

  // receiver: random stalls, calm stretches, and long hold-offs on request
  initial begin
    int unsigned holds_done;
    int unsigned hold_left;
    holds_done = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (holds_done != hold_req) begin
        holds_done++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < 25);
      end
    end
  end

  // result check, prediction on each input transfer, watchdog
  always @(posedge clk) begin
    vrrb_out_t want;
    vrrb_out_t pred;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_out++;
        status_hits[out_item.status]++;
        if (owed_results.size() == 0) begin
          log_mismatch("result with nothing owed, status", out_item.status, 0);
        end else begin
          want = owed_results.pop_front();
          if (out_item.status != want.status)
            log_mismatch("status", out_item.status, want.status);
          if (out_item.offset != want.offset)
            log_mismatch("offset", out_item.offset, want.offset);
          if (out_item.popped_bytes != want.popped_bytes)
            log_mismatch("popped_bytes", out_item.popped_bytes, want.popped_bytes);
          if (out_item.free_bytes != want.free_bytes)
            log_mismatch("free_bytes", out_item.free_bytes, want.free_bytes);
        end
      end
      if (in_valid && !in_stall) begin
        items_in++;
        pred = ring_step(in_item);
        owed_results.push_back(want_en ? want_val : pred);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WD_LIMIT) begin
          $display("no transfer for %0d cycles, %0d results owed", WD_LIMIT,
                   owed_results.size());
          $display("CHECK FAILED");
          $finish;
        end
      end
    end
  end

  // stimulus: directed table, then random phases over several capacities
  initial begin
    row_t     row;
    vrrb_in_t it;
    logic     filling;
    ring_cap   = SIZE_W'(BUF_BYTES);
    ring_head  = '0;
    ring_tail  = '0;
    ring_count = '0;
    filling    = 1'b1;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS_N; i++) begin
      row = DIR_ROWS[i];
      if (row.kind == ROW_CFG) begin
        write_capacity(row.value);
      end else begin
        it.action = (row.kind == ROW_POP) ? ACT_POP : ACT_PUSH;
        it.record_bytes = row.value;
        send_item(it, row.typed, row.want);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      write_capacity(PHASE_CAP[p]);
      calm <= (p == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // long receiver hold-off while items keep coming
        if (p == 0 && n == 40) hold_req <= hold_req + 1;
        // sender pause until the block has answered everything
        if (p == 1 && n == 80) wait_drained();
        if (n % BURST_ITEMS == 0) filling = 1'($urandom_range(0, 1));
        it = random_item(filling);
        send_item(it, 1'b0, NO_WANT);
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("run covered %0d transfers in and %0d results: %0d ok, %0d never fit, %0d no room, %0d empty",
             items_in, results_out, status_hits[ST_OK], status_hits[ST_NEVER],
             status_hits[ST_NOROOM], status_hits[ST_EMPTY]);
    $display("%0d capacity writes, %0d end-gap fillers, up to %0d dropped records freed in one pop",
             cap_writes, wrap_fills, max_skipped);
    if (fail_count == 0 && owed_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/vrrb_pkg.sv
sv/variable_record_ring_buffer.sv
bench/tb_top.sv
